// ===== hw/rtl/sod_pkg.sv =====
`timescale 1ns / 1ps

package sod_pkg;

  localparam int REQ_W       = 2;
  localparam int PIN_IDX_W   = 8;
  localparam int PIN_COUNT_W = 6;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [PIN_COUNT_W-1:0] PIN_COUNT_RST = 6'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET    = 2'd0,
    REQ_READ   = 2'd1,
    REQ_UPDATE = 2'd2
  } req_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHANGED      = 2'd0,
    MODE_ALWAYS       = 2'd1,
    MODE_ZERO_ALL     = 2'd2,
    MODE_ZERO_CHANGED = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIN_COUNT  = 1'b0,
    CFG_WRITE_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SHIFT = 1'b1
  } state_t;

endpackage

// ===== hw/rtl/sod_if.sv =====
`timescale 1ns / 1ps

interface sod_in_if;
  logic                           valid;
  logic                           ready;
  logic [sod_pkg::REQ_W-1:0]      req_type;
  logic [sod_pkg::PIN_IDX_W-1:0]  pin_index;
  logic                           pin_value;

  modport source (output valid, req_type, pin_index, pin_value, input ready);
  modport sink   (input valid, req_type, pin_index, pin_value, output ready);
endinterface

interface sod_out_if;
  logic valid;
  logic ready;
  logic serial_data;
  logic latch_pulse;
  logic read_value;
  logic last;

  modport source (output valid, serial_data, latch_pulse, read_value, last, input ready);
  modport sink   (input valid, serial_data, latch_pulse, read_value, last, output ready);
endinterface

// ===== hw/rtl/serial_output_expander_driver.sv =====
`timescale 1ns / 1ps

// Serial output expander driver.
// in_ch carries requests: set pin, read pin, update outputs. out_ch carries one
// transaction per shifted bit (serial_data, latch_pulse on the last bit of a
// pass, last on the final bit of the request) or one read transaction.
// cfg_we/cfg_index/cfg_wdata write pin_count (index 0) and write_mode (index 1);
// the user must write them only while idle; the block does not enforce this.
// A set gives no output. A read's result sits in the output register the next
// cycle. An update, after a setup step, shifts out n bits, or 2n with a pre-pass
// in modes 2 and 3, where n is the clamped pin count; an update with nothing to
// send gives no output. A bit counter walks the image through a single bit-select.
// in_ch.ready is low while an update is shifting.
// A result waits in the output register while out_ch.ready is low; shifting
// and new requests wait until it is taken.
// Reset (rst_n low, synchronous): images cleared, image marked modified so the
// first update sends, pin_count 32, write_mode 0, output register empty.
module serial_output_expander_driver #(
  parameter int MAX_PINS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sod_in_if.sink                             in_ch,
  sod_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [sod_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sod_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sod_pkg::*;

  localparam int N_W   = $clog2(MAX_PINS + 1);
  localparam int POS_W = $clog2(MAX_PINS);

  state_t                  state_r, state_nxt;
  logic [PIN_COUNT_W-1:0]  pin_count_r;
  mode_t                   write_mode_r;
  logic [MAX_PINS-1:0]     pin_image_r, pin_image_nxt;
  logic [MAX_PINS-1:0]     latched_image_r, latched_image_nxt;
  logic                    image_modified_r, image_modified_nxt;
  logic [MAX_PINS-1:0]     sh_r, sh_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    pre_r, pre_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_data_r, out_data_nxt;
  logic                    out_latch_r, out_latch_nxt;
  logic                    out_read_r, out_read_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [N_W-1:0]          n;
  logic [POS_W-1:0]        n_top;
  logic                    slot_free;
  logic                    in_fire;
  logic                    idx_ok;
  logic [POS_W-1:0]        idx;

  always_comb begin
    if (pin_count_r == '0) begin
      n = N_W'(1);
    end else if (32'(pin_count_r) > 32'(MAX_PINS)) begin
      n = N_W'(MAX_PINS);
    end else begin
      n = N_W'(pin_count_r);
    end
  end

  assign n_top     = POS_W'(n - N_W'(1));
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign idx_ok    = in_ch.pin_index < PIN_IDX_W'(n);
  assign idx       = in_ch.pin_index[POS_W-1:0];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.serial_data = out_data_r;
  assign out_ch.latch_pulse = out_latch_r;
  assign out_ch.read_value  = out_read_r;
  assign out_ch.last        = out_last_r;

  always_comb begin
    state_nxt          = state_r;
    pin_image_nxt      = pin_image_r;
    latched_image_nxt  = latched_image_r;
    image_modified_nxt = image_modified_r;
    sh_nxt             = sh_r;
    pos_nxt            = pos_r;
    pre_nxt            = pre_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_data_nxt       = out_data_r;
    out_latch_nxt      = out_latch_r;
    out_read_nxt       = out_read_r;
    out_last_nxt       = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.req_type)
            REQ_SET: begin
              if (idx_ok && (pin_image_r[idx] != in_ch.pin_value)) begin
                pin_image_nxt[idx] = in_ch.pin_value;
                image_modified_nxt = 1'b1;
              end
            end
            REQ_READ: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = 1'b0;
              out_latch_nxt = 1'b0;
              out_read_nxt  = idx_ok ? pin_image_r[idx] : 1'b0;
              out_last_nxt  = 1'b1;
            end
            REQ_UPDATE: begin
              if (image_modified_r || (write_mode_r == MODE_ALWAYS)) begin
                state_nxt          = ST_SHIFT;
                pos_nxt            = n_top;
                image_modified_nxt = 1'b0;
                latched_image_nxt  = pin_image_r;
                pre_nxt = (write_mode_r == MODE_ZERO_ALL) ||
                          (write_mode_r == MODE_ZERO_CHANGED);
                unique case (write_mode_r)
                  MODE_ZERO_ALL:     sh_nxt = '0;
                  MODE_ZERO_CHANGED: sh_nxt = latched_image_r & pin_image_r;
                  default:           sh_nxt = pin_image_r;
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sh_r[pos_r];
          out_latch_nxt = (pos_r == '0);
          out_read_nxt  = 1'b0;
          out_last_nxt  = (pos_r == '0) && !pre_r;
          if (pos_r == '0) begin
            if (pre_r) begin
              pre_nxt = 1'b0;
              sh_nxt  = pin_image_r;
              pos_nxt = n_top;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            pos_nxt = pos_r - POS_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      pin_count_r      <= PIN_COUNT_RST;
      write_mode_r     <= MODE_CHANGED;
      pin_image_r      <= '0;
      latched_image_r  <= '0;
      image_modified_r <= 1'b1;
      pre_r            <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      pin_image_r      <= pin_image_nxt;
      latched_image_r  <= latched_image_nxt;
      image_modified_r <= image_modified_nxt;
      pre_r            <= pre_nxt;
      out_valid_r      <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PIN_COUNT:  pin_count_r  <= cfg_wdata[PIN_COUNT_W-1:0];
          CFG_WRITE_MODE: write_mode_r <= mode_t'(cfg_wdata[MODE_W-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    pos_r       <= pos_nxt;
    out_data_r  <= out_data_nxt;
    out_latch_r <= out_latch_nxt;
    out_read_r  <= out_read_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_accept_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !out_valid_r || out_ch.ready)
    else $error("request accepted while result register blocked");

  a_shift_clears_mod: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> !image_modified_r)
    else $error("image still marked modified while shifting");

  a_prepass_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_latch_r && !out_last_r |-> state_r == ST_SHIFT && !pre_r)
    else $error("pre-pass latch without main pass following");

  a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_read_r |-> out_last_r && !out_latch_r && state_r == ST_IDLE)
    else $error("malformed read result");

endmodule

// ===== tb/tb_serial_output_expander_driver.sv =====
`timescale 1ns / 1ps

module tb_serial_output_expander_driver;
  import sod_pkg::*;

  localparam int MAX_PINS   = 32;
  localparam int STALL_MAX  = 3000;
  localparam int DRAIN_WAIT = 8;

  typedef struct packed {
    logic serial_data;
    logic latch_pulse;
    logic read_value;
    logic last;
  } shift_rec_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sod_in_if  in_ch ();
  sod_out_if out_ch ();

  serial_output_expander_driver #(.MAX_PINS(MAX_PINS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // expander image as the block should hold it
  logic [31:0]            pin_image;
  logic [31:0]            latched_image;
  logic                   image_modified;
  logic [PIN_COUNT_W-1:0] pin_count;
  mode_t                  write_mode;

  shift_rec_t expected_bits[$];

  int errors;
  int requests_done;
  int updates_done;
  int reads_done;
  int results_checked;
  int cfg_writes;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int active_pins();
    int n;
    n = pin_count;
    if (n > MAX_PINS) n = MAX_PINS;
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic void queue_pass(logic [31:0] bits, int n, bit closing);
    shift_rec_t rec;
    for (int i = n - 1; i >= 0; i--) begin
      rec.serial_data = bits[i];
      rec.latch_pulse = (i == 0);
      rec.read_value  = 1'b0;
      rec.last        = closing && (i == 0);
      expected_bits.push_back(rec);
    end
  endfunction

  function automatic void model_request(logic [REQ_W-1:0] rq, logic [PIN_IDX_W-1:0] idx,
                                        logic val);
    int n;
    shift_rec_t rec;
    n = active_pins();
    requests_done++;
    case (rq)
      REQ_SET: begin
        if (idx < n && pin_image[idx] != val) begin
          pin_image[idx] = val;
          image_modified = 1'b1;
        end
      end
      REQ_READ: begin
        rec = '0;
        rec.read_value = (idx < n) ? pin_image[idx] : 1'b0;
        rec.last = 1'b1;
        expected_bits.push_back(rec);
        reads_done++;
      end
      REQ_UPDATE: begin
        if (image_modified || write_mode == MODE_ALWAYS) begin
          if (write_mode == MODE_ZERO_ALL)
            queue_pass('0, n, 1'b0);
          else if (write_mode == MODE_ZERO_CHANGED)
            queue_pass(latched_image & pin_image, n, 1'b0);
          queue_pass(pin_image, n, 1'b1);
          image_modified = 1'b0;
          latched_image = pin_image;
          updates_done++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [REQ_W-1:0] rq, logic [PIN_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rq;
    in_ch.pin_index <= idx;
    in_ch.pin_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    model_request(rq, idx, val);
  endtask

  task automatic write_register(cfg_idx_t which, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_PIN_COUNT)
      pin_count = data;
    else
      write_mode = mode_t'(data[MODE_W-1:0]);
    cfg_writes++;
  endtask

  task automatic check_field(string name, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    shift_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bits.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %b%b%b%b", $time,
                 out_ch.serial_data, out_ch.latch_pulse, out_ch.read_value, out_ch.last);
        errors++;
      end else begin
        want = expected_bits.pop_front();
        check_field("serial_data", want.serial_data, out_ch.serial_data);
        check_field("latch_pulse", want.latch_pulse, out_ch.latch_pulse);
        check_field("read_value", want.read_value, out_ch.read_value);
        check_field("last", want.last, out_ch.last);
        results_checked++;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 13);
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_MAX) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results still expected", $time,
             STALL_MAX, expected_bits.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_after_reset();
    send_request(REQ_READ, 8'd0, 1'b0);
    send_request(REQ_READ, 8'd31, 1'b1);
    send_request(REQ_UPDATE, 8'd0, 1'b0);
    send_request(REQ_UPDATE, 8'hFF, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_request(REQ_SET, 8'd31, 1'b1);
    send_request(REQ_SET, 8'd0, 1'b1);
    send_request(REQ_SET, 8'd32, 1'b1);
    send_request(REQ_SET, 8'hFF, 1'b1);
    send_request(REQ_READ, 8'hFF, 1'b0);
    send_request(REQ_READ, 8'd31, 1'b0);
    send_request(2'd3, 8'hFF, 1'b1);
    send_request(REQ_UPDATE, 8'd0, 1'b0);
    send_request(REQ_SET, 8'd0, 1'b1);
    send_request(REQ_UPDATE, 8'd0, 1'b0);
  endtask

  task automatic test_pin_counts();
    write_register(CFG_PIN_COUNT, 6'd0);
    send_request(REQ_READ, 8'd1, 1'b0);
    send_request(REQ_SET, 8'd0, 1'b0);
    send_request(REQ_UPDATE, 8'd0, 1'b0);
    write_register(CFG_PIN_COUNT, 6'd63);
    send_request(REQ_READ, 8'd31, 1'b0);
  endtask

  task automatic test_write_modes();
    write_register(CFG_WRITE_MODE, CFG_DATA_W'(MODE_ALWAYS));
    send_request(REQ_UPDATE, 8'd0, 1'b0);
    write_register(CFG_WRITE_MODE, CFG_DATA_W'(MODE_ZERO_ALL));
    send_request(REQ_SET, 8'd5, 1'b1);
    send_request(REQ_UPDATE, 8'd0, 1'b0);
    write_register(CFG_WRITE_MODE, CFG_DATA_W'(MODE_ZERO_CHANGED));
    send_request(REQ_SET, 8'd5, 1'b0);
    send_request(REQ_SET, 8'd6, 1'b1);
    send_request(REQ_UPDATE, 8'd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] counts[7] = '{6'd1, 6'd63, 6'd5, 6'd32, 6'd0, 6'd9, 6'd17};
    int done;
    int n;
    int sets;
    for (int p = 0; p < 7; p++) begin
      if (p == 5) counts[p] = CFG_DATA_W'($urandom_range(2, 31));
      write_register(CFG_PIN_COUNT, counts[p]);
      write_register(CFG_WRITE_MODE, CFG_DATA_W'(p % 4));
      no_idle = (p == 3);
      n = active_pins();
      done = 0;
      while (done < 60) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any request code, the unused one too, and a pin anywhere in the index range
          send_request(REQ_W'($urandom_range(0, 3)), PIN_IDX_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
          done++;
        end else begin
          sets = $urandom_range(0, 4);
          for (int s = 0; s < sets; s++)
            send_request(REQ_SET, PIN_IDX_W'($urandom_range(0, n - 1)),
                         1'($urandom_range(0, 1)));
          if ($urandom_range(0, 2) == 0)
            send_request(REQ_READ, PIN_IDX_W'($urandom_range(0, n - 1)),
                         1'($urandom_range(0, 1)));
          send_request(REQ_UPDATE, PIN_IDX_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
          done += sets + 2;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_PIN_COUNT;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_SET;
    in_ch.pin_index = '0;
    in_ch.pin_value = 1'b0;
    no_idle         = 1'b0;
    errors          = 0;
    requests_done   = 0;
    updates_done    = 0;
    reads_done      = 0;
    results_checked = 0;
    cfg_writes      = 0;
    pin_image       = '0;
    latched_image   = '0;
    image_modified  = 1'b1;
    pin_count       = PIN_COUNT_RST;
    write_mode      = MODE_CHANGED;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_field_extremes();
    test_pin_counts();
    test_write_modes();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests: %0d updates shifted out, %0d reads, %0d register writes",
             requests_done, updates_done, reads_done, cfg_writes);
    $display("Checked %0d output transactions across pin counts 1..32 and all write modes",
             results_checked);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
